FILE: design/dpu_pkg.sv
// shared types and constants of the depth pixel unprojection block
`default_nettype none

package dpu_pkg;

	// widths fixed by the field definitions
	localparam int DATA_W    = 16;
	localparam int POINT_W   = 32;
	localparam int CFG_IDX_W = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MAX = 3'd5;

	// reset values of the depth band
	localparam logic [DATA_W-1:0] DEPTH_MIN_RST = 16'd100;
	localparam logic [DATA_W-1:0] DEPTH_MAX_RST = 16'd3000;

	// entries of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// camera intrinsics and depth band
	typedef struct packed {
		logic [DATA_W-1:0] focal_x;
		logic [DATA_W-1:0] focal_y;
		logic [DATA_W-1:0] centre_x;
		logic [DATA_W-1:0] centre_y;
		logic [DATA_W-1:0] depth_min;
		logic [DATA_W-1:0] depth_max;
	} cfg_t;

	// per-point data that rides along with the coordinate math
	typedef struct packed {
		logic              neg_x;
		logic              neg_y;
		logic [DATA_W-1:0] depth;
		rgb_t              colour;
	} meta_t;

endpackage

`default_nettype wire

FILE: design/dpu_if.sv
// handshake interfaces for the pixel input and point output channels
`default_nettype none

interface dpu_in_if #(
	parameter int COORD_BITS = 12
) ();
	logic                       valid;
	logic                       ready;
	logic [dpu_pkg::DATA_W-1:0] depth_mm;
	logic [COORD_BITS-1:0]      pixel_col;
	logic [COORD_BITS-1:0]      pixel_row;
	logic [7:0]                 red_in;
	logic [7:0]                 green_in;
	logic [7:0]                 blue_in;

	modport source (
		output valid, depth_mm, pixel_col, pixel_row, red_in, green_in, blue_in,
		input  ready
	);
	modport sink (
		input  valid, depth_mm, pixel_col, pixel_row, red_in, green_in, blue_in,
		output ready
	);
endinterface

interface dpu_out_if ();
	logic                               valid;
	logic                               ready;
	logic signed [dpu_pkg::POINT_W-1:0] point_x;
	logic signed [dpu_pkg::POINT_W-1:0] point_y;
	logic [dpu_pkg::DATA_W-1:0]         point_z;
	logic [7:0]                         red_out;
	logic [7:0]                         green_out;
	logic [7:0]                         blue_out;

	modport source (
		output valid, point_x, point_y, point_z, red_out, green_out, blue_out,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z, red_out, green_out, blue_out,
		output ready
	);
endinterface

`default_nettype wire

FILE: design/dpu_front.sv
// front end: takes pixel words, drops invalid depths, forms signed pixel offsets
`default_nettype none

module dpu_front #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 4
) (
	dpu_in_if.sink          pix_in,
	input  dpu_pkg::cfg_t   cfg,
	input  logic            q_full,
	output logic            push,
	output logic [2*((COORD_BITS + FRAC_BITS > dpu_pkg::DATA_W) ?
		(COORD_BITS + FRAC_BITS) : dpu_pkg::DATA_W) + $bits(dpu_pkg::meta_t) - 1:0] word
);

	localparam int PIX_W = COORD_BITS + FRAC_BITS;
	localparam int MAG_W = (PIX_W > dpu_pkg::DATA_W) ? PIX_W : dpu_pkg::DATA_W;

	logic [MAG_W-1:0]  pix_x, pix_y, ctr_x, ctr_y;
	logic [MAG_W-1:0]  mag_x, mag_y;
	logic              neg_x, neg_y;
	logic              keep;
	dpu_pkg::meta_t    meta;

	// pixel position in the intrinsics' fixed point
	assign pix_x = MAG_W'(PIX_W'(pix_in.pixel_col) << FRAC_BITS);
	assign pix_y = MAG_W'(PIX_W'(pix_in.pixel_row) << FRAC_BITS);
	assign ctr_x = MAG_W'(cfg.centre_x);
	assign ctr_y = MAG_W'(cfg.centre_y);

	// offset from the principal point as sign and magnitude
	assign neg_x = pix_x < ctr_x;
	assign neg_y = pix_y < ctr_y;
	assign mag_x = neg_x ? (ctr_x - pix_x) : (pix_x - ctr_x);
	assign mag_y = neg_y ? (ctr_y - pix_y) : (pix_y - ctr_y);

	// a point comes out only for a depth inside the band and nonzero focal lengths
	assign keep = (cfg.focal_x != '0) && (cfg.focal_y != '0) &&
		(pix_in.depth_mm != '0) &&
		(pix_in.depth_mm >= cfg.depth_min) && (pix_in.depth_mm <= cfg.depth_max);

	// handshake: ready only hangs on the queue fill
	assign pix_in.ready = !q_full;
	assign push         = pix_in.valid && !q_full && keep;

	// queue word
	always_comb begin
		meta.neg_x        = neg_x;
		meta.neg_y        = neg_y;
		meta.depth        = pix_in.depth_mm;
		meta.colour.red   = pix_in.red_in;
		meta.colour.green = pix_in.green_in;
		meta.colour.blue  = pix_in.blue_in;
	end

	assign word = {mag_x, mag_y, meta};

endmodule

`default_nettype wire

FILE: design/dpu_queue.sv
// short register queue that decouples the front end from the arithmetic back end
`default_nettype none

module dpu_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign dout      = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

FILE: design/dpu_back.sv
// back end: offset times depth, pipelined restoring divide by focal, saturation
`default_nettype none

module dpu_back #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dpu_pkg::cfg_t        cfg,
	input  logic                 q_valid,
	input  logic [2*((COORD_BITS + FRAC_BITS > dpu_pkg::DATA_W) ?
		(COORD_BITS + FRAC_BITS) : dpu_pkg::DATA_W) + $bits(dpu_pkg::meta_t) - 1:0] q_word,
	output logic                 pop,
	dpu_out_if.source            pt_out
);

	localparam int DATA_W  = dpu_pkg::DATA_W;
	localparam int POINT_W = dpu_pkg::POINT_W;
	localparam int PIX_W   = COORD_BITS + FRAC_BITS;
	localparam int MAG_W   = (PIX_W > DATA_W) ? PIX_W : DATA_W;
	localparam int PROD_W  = MAG_W + DATA_W;
	localparam int NUM_W   = PROD_W + FRAC_BITS;
	localparam int QX_W    = (NUM_W > POINT_W) ? NUM_W : POINT_W + 1;
	localparam logic [POINT_W-1:0] PT_MIN = {1'b1, {(POINT_W - 1){1'b0}}};
	localparam logic [POINT_W-1:0] PT_MAX = ~PT_MIN;

	// signed saturation of a quotient magnitude
	function automatic logic [POINT_W-1:0] saturate(input logic [QX_W-1:0] q,
		input logic neg);
		logic over_pos;
		logic over_neg;
		over_pos = |q[QX_W-1:POINT_W-1];
		over_neg = (|q[QX_W-1:POINT_W]) || (q[POINT_W-1] && (|q[POINT_W-2:0]));
		if (neg) begin
			saturate = over_neg ? PT_MIN : -q[POINT_W-1:0];
		end else begin
			saturate = over_pos ? PT_MAX : q[POINT_W-1:0];
		end
	endfunction

	logic               en;
	logic [MAG_W-1:0]   mag_x, mag_y;
	dpu_pkg::meta_t     meta;

	logic               vld_s1;
	logic [PROD_W-1:0]  prod_x_s1, prod_y_s1;
	dpu_pkg::meta_t     meta_s1;
	logic [NUM_W-1:0]   num_x, num_y;

	logic               div_vld_s  [NUM_W];
	logic [NUM_W-1:0]   div_nq_x_s [NUM_W];
	logic [NUM_W-1:0]   div_nq_y_s [NUM_W];
	logic [DATA_W-1:0]  div_rem_x_s[NUM_W];
	logic [DATA_W-1:0]  div_rem_y_s[NUM_W];
	dpu_pkg::meta_t     div_meta_s [NUM_W];

	logic               out_vld_q;
	logic [POINT_W-1:0] out_x_q, out_y_q;
	dpu_pkg::meta_t     out_meta_q;

	// whole pipeline moves unless the output word is held
	assign en  = !out_vld_q || pt_out.ready;
	assign pop = en && q_valid;

	assign {mag_x, mag_y, meta} = q_word;

	// stage 1: offset times depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= PROD_W'(mag_x) * PROD_W'(meta.depth);
			prod_y_s1 <= PROD_W'(mag_y) * PROD_W'(meta.depth);
			meta_s1   <= meta;
		end
	end

	// numerator scaled to output fixed point
	assign num_x = NUM_W'(prod_x_s1) << FRAC_BITS;
	assign num_y = NUM_W'(prod_y_s1) << FRAC_BITS;

	// divider: one quotient bit per stage, dividend shifts out as quotient shifts in
	for (genvar k = 0; k < NUM_W; k++) begin : g_div
		logic              v_in;
		logic [NUM_W-1:0]  nq_x_in, nq_y_in;
		logic [DATA_W-1:0] rx_in, ry_in;
		dpu_pkg::meta_t    m_in;
		logic [DATA_W:0]   tx, ty;
		logic              gx, gy;

		if (k == 0) begin : g_first
			assign v_in    = vld_s1;
			assign nq_x_in = num_x;
			assign nq_y_in = num_y;
			assign rx_in   = '0;
			assign ry_in   = '0;
			assign m_in    = meta_s1;
		end else begin : g_next
			assign v_in    = div_vld_s[k-1];
			assign nq_x_in = div_nq_x_s[k-1];
			assign nq_y_in = div_nq_y_s[k-1];
			assign rx_in   = div_rem_x_s[k-1];
			assign ry_in   = div_rem_y_s[k-1];
			assign m_in    = div_meta_s[k-1];
		end

		// trial subtract
		assign tx = {rx_in, nq_x_in[NUM_W-1]};
		assign ty = {ry_in, nq_y_in[NUM_W-1]};
		assign gx = tx >= {1'b0, cfg.focal_x};
		assign gy = ty >= {1'b0, cfg.focal_y};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else if (en) begin
				div_vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_x_s[k] <= gx ? DATA_W'(tx - {1'b0, cfg.focal_x}) : tx[DATA_W-1:0];
				div_rem_y_s[k] <= gy ? DATA_W'(ty - {1'b0, cfg.focal_y}) : ty[DATA_W-1:0];
				div_nq_x_s[k]  <= {nq_x_in[NUM_W-2:0], gx};
				div_nq_y_s[k]  <= {nq_y_in[NUM_W-2:0], gy};
				div_meta_s[k]  <= m_in;
			end
		end
	end

	// output register: sign and saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= div_vld_s[NUM_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_x_q    <= saturate(QX_W'(div_nq_x_s[NUM_W-1]), div_meta_s[NUM_W-1].neg_x);
			out_y_q    <= saturate(QX_W'(div_nq_y_s[NUM_W-1]), div_meta_s[NUM_W-1].neg_y);
			out_meta_q <= div_meta_s[NUM_W-1];
		end
	end

	assign pt_out.valid     = out_vld_q;
	assign pt_out.point_x   = out_x_q;
	assign pt_out.point_y   = out_y_q;
	assign pt_out.point_z   = out_meta_q.depth;
	assign pt_out.red_out   = out_meta_q.colour.red;
	assign pt_out.green_out = out_meta_q.colour.green;
	assign pt_out.blue_out  = out_meta_q.colour.blue;

`ifndef SYNTH
	a_stall_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !pt_out.ready) |-> !pop) else $error("queue drained during stall");
	a_depth_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_meta_q.depth != '0)) else $error("point with zero depth");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_s[NUM_W-1] |-> ((div_rem_x_s[NUM_W-1] < cfg.focal_x) &&
		(div_rem_y_s[NUM_W-1] < cfg.focal_y))) else $error("divider remainder too large");
`endif

endmodule

`default_nettype wire

FILE: design/depth_pixel_unprojection_top.sv
// Depth pixel unprojection: pinhole camera model from depth pixels to coloured points.
// pix_in takes one word per pixel: depth in mm, column, row and RGB colour.
// pt_out gives one word per pixel whose depth is nonzero and inside
// [depth_min, depth_max] while both focal lengths are nonzero; other pixels are
// taken and dropped. Point x and y are in 1/2^FRAC_BITS mm, z in mm.
// Throughput: one pixel per cycle unless pt_out stalls, set by the pipelined divider
// that retires one quotient bit per stage. Path from input accept to output valid:
// queue entry, stage 1 product register, the divider stages for a quotient of
// NUM_W = max(COORD_BITS + FRAC_BITS, 16) + 16 + FRAC_BITS bits, output register.
// Configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
// index 0..5 = focal_x, focal_y, centre_x, centre_y, depth_min, depth_max.
// Reset: focal lengths and principal point go to zero, band to 100..3000 mm,
// so no points come out until the focal lengths are written; pipeline emptied.
// Receiver stall: the whole arithmetic pipeline holds, the two-entry queue in
// front of it fills, then pix_in.ready drops.
`default_nettype none

module depth_pixel_unprojection_top #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dpu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dpu_pkg::DATA_W-1:0]    cfg_data,
	dpu_in_if.sink                        pix_in,
	dpu_out_if.source                     pt_out
);

	localparam int PIX_W   = COORD_BITS + FRAC_BITS;
	localparam int MAG_W   = (PIX_W > dpu_pkg::DATA_W) ? PIX_W : dpu_pkg::DATA_W;
	localparam int ENTRY_W = 2 * MAG_W + $bits(dpu_pkg::meta_t);

	dpu_pkg::cfg_t      cfg_q;
	logic               push, q_full, q_valid, pop;
	logic [ENTRY_W-1:0] push_word, q_word;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x   <= '0;
			cfg_q.focal_y   <= '0;
			cfg_q.centre_x  <= '0;
			cfg_q.centre_y  <= '0;
			cfg_q.depth_min <= dpu_pkg::DEPTH_MIN_RST;
			cfg_q.depth_max <= dpu_pkg::DEPTH_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpu_pkg::REG_FOCAL_X:   cfg_q.focal_x   <= cfg_data;
				dpu_pkg::REG_FOCAL_Y:   cfg_q.focal_y   <= cfg_data;
				dpu_pkg::REG_CENTRE_X:  cfg_q.centre_x  <= cfg_data;
				dpu_pkg::REG_CENTRE_Y:  cfg_q.centre_y  <= cfg_data;
				dpu_pkg::REG_DEPTH_MIN: cfg_q.depth_min <= cfg_data;
				dpu_pkg::REG_DEPTH_MAX: cfg_q.depth_max <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// pixel classification and offsets
	dpu_front #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.pix_in (pix_in),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push),
		.word   (push_word)
	);

	// decoupling queue
	dpu_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (dpu_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (push_word),
		.full      (q_full),
		.pop       (pop),
		.dout      (q_word),
		.not_empty (q_valid)
	);

	// multiply, divide and saturate
	dpu_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_word  (q_word),
		.pop     (pop),
		.pt_out  (pt_out)
	);

endmodule

`default_nettype wire
